// File: design/brs_pkg.sv
// brs_pkg: shared widths, types and register codes of the bilinear resize sampler
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package brs_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int FRAC_BITS      = 8;

  localparam int CW   = 12;                          // coordinate and target size width
  localparam int SZW  = 9;                           // source size register width
  localparam int PXW  = 32;
  localparam int XW   = $clog2(MAX_SRC_WIDTH);
  localparam int YW   = $clog2(MAX_SRC_HEIGHT);
  localparam int DW   = CW + 1;                      // divisor 2*target
  localparam int PRW  = CW + 1 + SZW;                // (2d+1)*src
  localparam int NW   = PRW + FRAC_BITS;             // numerator
  localparam int NW1  = NW + 1;
  localparam int QB   = ((XW > YW) ? XW : YW) + FRAC_BITS;
  localparam int BAW  = XW + YW - 2;                 // bank address width
  localparam int BANK_DEPTH = 1 << BAW;
  localparam int HW   = 8 + FRAC_BITS + 1;           // horizontal blend width
  localparam int VW   = HW + FRAC_BITS + 1;          // vertical blend width

  localparam int MID_DEPTH = 4;
  localparam int MCW       = $clog2(MID_DEPTH + 1);
  localparam int MPW       = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH = 4;
  localparam int OCW       = $clog2(OUT_DEPTH + 1);
  localparam int OPW       = $clog2(OUT_DEPTH);

  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_SRC_W = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_SRC_H = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_DST_W = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_DST_H = 3'd3;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef logic [CW-1:0]        dim_t;
  typedef logic [SZW-1:0]       sz_t;
  typedef logic [PRW-1:0]       prod_t;
  typedef logic [NW-1:0]        num_t;
  typedef logic [NW1-1:0]       numx_t;
  typedef logic [QB-1:0]        q_t;
  typedef logic [XW-1:0]        xc_t;
  typedef logic [YW-1:0]        yc_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [FRAC_BITS:0]   wgt_t;
  typedef logic [HW-1:0]        hsum_t;
  typedef logic [VW-1:0]        vsum_t;

  // item as it travels through the front pipeline
  typedef struct packed {
    logic           kind;      // 1 = sample
    logic           ok;
    logic           wen;
    dim_t           cx;
    dim_t           cy;
    logic [PXW-1:0] pix;
  } front_t;

  // classified word handed from front to back
  typedef struct packed {
    logic           kind;
    logic           ok;
    logic           wen;
    xc_t            x0;
    xc_t            x1;
    yc_t            y0;
    yc_t            y1;
    frac_t          fx;
    frac_t          fy;
    logic [PXW-1:0] pix;
  } mid_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } res_t;

endpackage
`default_nettype wire

// File: design/brs_front.sv
// brs_front: accepts words, checks ranges, maps sample coordinates to source
// fixed point through a pipelined restoring divider; uses brs_pkg
`timescale 1ns / 1ps
`default_nettype none
module brs_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic                 in_req_type,
  input  wire brs_pkg::dim_t        in_coord_x,
  input  wire brs_pkg::dim_t        in_coord_y,
  input  wire logic [31:0]          in_pixel_word,
  input  wire brs_pkg::sz_t         src_w,
  input  wire brs_pkg::sz_t         src_h,
  input  wire brs_pkg::dim_t        dst_w,
  input  wire brs_pkg::dim_t        dst_h,
  input  wire logic                 q_full,
  output logic                      q_push,
  output brs_pkg::mid_t             q_data
);

  localparam int QB = brs_pkg::QB;
  localparam int F  = brs_pkg::FRAC_BITS;

  logic en;
  brs_pkg::front_t pin;

  logic            v0_r, v1_r;
  brs_pkg::front_t p0_r, p1_r;
  brs_pkg::prod_t  prx_r, pry_r;
  brs_pkg::prod_t  prx_nxt, pry_nxt;

  logic            vd_r   [QB+1];
  brs_pkg::front_t pd_r   [QB+1];
  brs_pkg::num_t   rx_r   [QB+1];
  brs_pkg::num_t   ry_r   [QB+1];
  brs_pkg::q_t     qx_r   [QB+1];
  brs_pkg::q_t     qy_r   [QB+1];
  logic            satx_r [QB+1];
  logic            saty_r [QB+1];

  brs_pkg::num_t   rx_nxt [QB+1];
  brs_pkg::num_t   ry_nxt [QB+1];
  brs_pkg::q_t     qx_nxt [QB+1];
  brs_pkg::q_t     qy_nxt [QB+1];
  logic            satx_nxt, saty_nxt;

  logic [brs_pkg::DW-1:0] dx, dy;
  brs_pkg::q_t limx, limy, sx, sy;
  brs_pkg::xc_t x0;
  brs_pkg::yc_t y0;

  assign en      = !q_full;
  assign in_full = !en;
  assign dx      = {dst_w, 1'b0};
  assign dy      = {dst_h, 1'b0};

  always_comb begin
    pin.kind = (in_req_type == brs_pkg::REQ_SAMPLE);
    pin.cx   = in_coord_x;
    pin.cy   = in_coord_y;
    pin.pix  = in_pixel_word;
    pin.ok   = (in_req_type == brs_pkg::REQ_SAMPLE) && (src_w != '0) && (src_h != '0) &&
               (in_coord_x < dst_w) && (in_coord_y < dst_h);
    pin.wen  = (in_req_type == brs_pkg::REQ_WRITE) &&
               (int'(in_coord_x) < brs_pkg::MAX_SRC_WIDTH) &&
               (int'(in_coord_y) < brs_pkg::MAX_SRC_HEIGHT);
  end

  // products, numerators and divider stages
  always_comb begin
    prx_nxt = brs_pkg::prod_t'({p0_r.cx, 1'b1}) * brs_pkg::prod_t'(src_w);
    pry_nxt = brs_pkg::prod_t'({p0_r.cy, 1'b1}) * brs_pkg::prod_t'(src_h);

    if (prx_r > brs_pkg::prod_t'(dst_w)) begin
      rx_nxt[0] = brs_pkg::num_t'(prx_r - brs_pkg::prod_t'(dst_w)) << F;
    end else begin
      rx_nxt[0] = '0;
    end
    if (pry_r > brs_pkg::prod_t'(dst_h)) begin
      ry_nxt[0] = brs_pkg::num_t'(pry_r - brs_pkg::prod_t'(dst_h)) << F;
    end else begin
      ry_nxt[0] = '0;
    end
    qx_nxt[0] = '0;
    qy_nxt[0] = '0;
    satx_nxt = {1'b0, rx_nxt[0]} >= (brs_pkg::numx_t'(dx) << QB);
    saty_nxt = {1'b0, ry_nxt[0]} >= (brs_pkg::numx_t'(dy) << QB);

    for (int j = 0; j < QB; j++) begin
      if ({1'b0, rx_r[j]} >= (brs_pkg::numx_t'(dx) << (QB - 1 - j))) begin
        rx_nxt[j+1] = brs_pkg::num_t'({1'b0, rx_r[j]} -
                                      (brs_pkg::numx_t'(dx) << (QB - 1 - j)));
        qx_nxt[j+1] = qx_r[j] | (brs_pkg::q_t'(1) << (QB - 1 - j));
      end else begin
        rx_nxt[j+1] = rx_r[j];
        qx_nxt[j+1] = qx_r[j];
      end
      if ({1'b0, ry_r[j]} >= (brs_pkg::numx_t'(dy) << (QB - 1 - j))) begin
        ry_nxt[j+1] = brs_pkg::num_t'({1'b0, ry_r[j]} -
                                      (brs_pkg::numx_t'(dy) << (QB - 1 - j)));
        qy_nxt[j+1] = qy_r[j] | (brs_pkg::q_t'(1) << (QB - 1 - j));
      end else begin
        ry_nxt[j+1] = ry_r[j];
        qy_nxt[j+1] = qy_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      for (int j = 0; j <= QB; j++) begin
        vd_r[j] <= 1'b0;
      end
    end else if (en) begin
      v0_r    <= in_push;
      v1_r    <= v0_r;
      vd_r[0] <= v1_r;
      for (int j = 0; j < QB; j++) begin
        vd_r[j+1] <= vd_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r      <= pin;
      p1_r      <= p0_r;
      prx_r     <= prx_nxt;
      pry_r     <= pry_nxt;
      pd_r[0]   <= p1_r;
      satx_r[0] <= satx_nxt;
      saty_r[0] <= saty_nxt;
      for (int j = 0; j <= QB; j++) begin
        rx_r[j] <= rx_nxt[j];
        ry_r[j] <= ry_nxt[j];
        qx_r[j] <= qx_nxt[j];
        qy_r[j] <= qy_nxt[j];
      end
      for (int j = 0; j < QB; j++) begin
        pd_r[j+1]   <= pd_r[j];
        satx_r[j+1] <= satx_r[j];
        saty_r[j+1] <= saty_r[j];
      end
    end
  end

  // clamp and neighbour selection
  always_comb begin
    limx = brs_pkg::q_t'(src_w - brs_pkg::sz_t'(1)) << F;
    limy = brs_pkg::q_t'(src_h - brs_pkg::sz_t'(1)) << F;
    sx   = (satx_r[QB] || (qx_r[QB] > limx)) ? limx : qx_r[QB];
    sy   = (saty_r[QB] || (qy_r[QB] > limy)) ? limy : qy_r[QB];
    x0   = sx[F +: brs_pkg::XW];
    y0   = sy[F +: brs_pkg::YW];

    q_push      = en && vd_r[QB];
    q_data.kind = pd_r[QB].kind;
    q_data.ok   = pd_r[QB].ok;
    q_data.wen  = pd_r[QB].wen;
    q_data.pix  = pd_r[QB].pix;
    q_data.fx   = sx[F-1:0];
    q_data.fy   = sy[F-1:0];
    if (pd_r[QB].kind) begin
      q_data.x0 = x0;
      q_data.y0 = y0;
    end else begin
      q_data.x0 = pd_r[QB].cx[brs_pkg::XW-1:0];
      q_data.y0 = pd_r[QB].cy[brs_pkg::YW-1:0];
    end
    if (brs_pkg::sz_t'(x0) + brs_pkg::sz_t'(1) < src_w) begin
      q_data.x1 = brs_pkg::xc_t'(brs_pkg::sz_t'(x0) + brs_pkg::sz_t'(1));
    end else begin
      q_data.x1 = brs_pkg::xc_t'(src_w - brs_pkg::sz_t'(1));
    end
    if (brs_pkg::sz_t'(y0) + brs_pkg::sz_t'(1) < src_h) begin
      q_data.y1 = brs_pkg::yc_t'(brs_pkg::sz_t'(y0) + brs_pkg::sz_t'(1));
    end else begin
      q_data.y1 = brs_pkg::yc_t'(src_h - brs_pkg::sz_t'(1));
    end
  end

endmodule
`default_nettype wire

// File: design/brs_mid_queue.sv
// brs_mid_queue: short queue of classified words between front and back
// uses brs_pkg for the word type and depth
`timescale 1ns / 1ps
`default_nettype none
module brs_mid_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire brs_pkg::mid_t push_data,
  input  wire logic          pop,
  output brs_pkg::mid_t      head,
  output logic               full,
  output logic               empty
);

  brs_pkg::mid_t                 ent_r [brs_pkg::MID_DEPTH];
  logic [brs_pkg::MPW-1:0]       wp_r, rp_r;
  logic [brs_pkg::MCW-1:0]       cnt_r;

  assign full  = (cnt_r == brs_pkg::MCW'(brs_pkg::MID_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= brs_pkg::MPW'(wp_r + 1'b1);
      end
      if (pop) begin
        rp_r <= brs_pkg::MPW'(rp_r + 1'b1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: design/brs_back.sv
// brs_back: four-bank image store, neighbour fetch and bilinear blend
// uses brs_pkg; fed from brs_mid_queue, drives the result queue in the top level
`timescale 1ns / 1ps
`default_nettype none
module brs_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire brs_pkg::mid_t head,
  input  wire logic          q_empty,
  output logic               q_pop,
  input  wire logic          res_space,
  output logic               res_push,
  output brs_pkg::res_t      res_data
);

  localparam int F  = brs_pkg::FRAC_BITS;
  localparam int XW = brs_pkg::XW;
  localparam int YW = brs_pkg::YW;

  logic en;
  logic [31:0]            mem   [4][brs_pkg::BANK_DEPTH];
  logic [brs_pkg::BAW-1:0] raddr [4];
  logic [brs_pkg::BAW-1:0] waddr;
  logic [1:0]             wbank;
  logic                   we;
  brs_pkg::xc_t           col [4];
  brs_pkg::yc_t           row [4];

  logic [31:0]   rd_r [4];
  logic          v1_r, ok1_r;
  brs_pkg::frac_t fx1_r, fy1_r;
  logic [1:0]    s00_r, s10_r, s01_r, s11_r;

  logic          v2_r, ok2_r;
  brs_pkg::frac_t fy2_r;
  brs_pkg::hsum_t top_r [4];
  brs_pkg::hsum_t bot_r [4];
  brs_pkg::hsum_t top_nxt [4];
  brs_pkg::hsum_t bot_nxt [4];

  logic          v3_r;
  brs_pkg::res_t res_r;
  brs_pkg::res_t res_nxt;
  brs_pkg::vsum_t vs [4];
  logic [7:0]    chv [4];

  assign en    = res_space;
  assign q_pop = en && !q_empty;
  assign we    = q_pop && !head.kind && head.wen;
  assign wbank = {head.y0[0], head.x0[0]};
  assign waddr = {head.y0[YW-1:1], head.x0[XW-1:1]};

  // each bank holds one parity of column and row
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      col[b]   = (head.x0[0] == b[0]) ? head.x0 : head.x1;
      row[b]   = (head.y0[0] == b[1]) ? head.y0 : head.y1;
      raddr[b] = {row[b][YW-1:1], col[b][XW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      if (we && (wbank == 2'(b))) begin
        mem[b][waddr] <= head.pix;
      end
      if (en) begin
        rd_r[b] <= mem[b][raddr[b]];
      end
    end
  end

  always_comb begin
    logic [7:0] t00, t10, t01, t11;
    for (int c = 0; c < 4; c++) begin
      t00 = rd_r[s00_r][8*c +: 8];
      t10 = rd_r[s10_r][8*c +: 8];
      t01 = rd_r[s01_r][8*c +: 8];
      t11 = rd_r[s11_r][8*c +: 8];
      top_nxt[c] = brs_pkg::hsum_t'(t00) * brs_pkg::hsum_t'(brs_pkg::wgt_t'(1 << F) - fx1_r) +
                   brs_pkg::hsum_t'(t10) * brs_pkg::hsum_t'(fx1_r);
      bot_nxt[c] = brs_pkg::hsum_t'(t01) * brs_pkg::hsum_t'(brs_pkg::wgt_t'(1 << F) - fx1_r) +
                   brs_pkg::hsum_t'(t11) * brs_pkg::hsum_t'(fx1_r);
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      vs[c] = brs_pkg::vsum_t'(top_r[c]) *
                brs_pkg::vsum_t'(brs_pkg::wgt_t'(1 << F) - fy2_r) +
              brs_pkg::vsum_t'(bot_r[c]) * brs_pkg::vsum_t'(fy2_r);
      if ((vs[c] >> (2 * F)) > brs_pkg::vsum_t'(255)) begin
        chv[c] = 8'hff;
      end else begin
        chv[c] = 8'(vs[c] >> (2 * F));
      end
      if (!ok2_r) begin
        chv[c] = 8'h00;
      end
    end
    res_nxt.ok    = ok2_r;
    res_nxt.blue  = chv[0];
    res_nxt.green = chv[1];
    res_nxt.red   = chv[2];
    res_nxt.alpha = chv[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= q_pop && head.kind;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1_r <= head.ok;
      fx1_r <= head.fx;
      fy1_r <= head.fy;
      s00_r <= {head.y0[0], head.x0[0]};
      s10_r <= {head.y0[0], head.x1[0]};
      s01_r <= {head.y1[0], head.x0[0]};
      s11_r <= {head.y1[0], head.x1[0]};
      ok2_r <= ok1_r;
      fy2_r <= fy1_r;
      for (int c = 0; c < 4; c++) begin
        top_r[c] <= top_nxt[c];
        bot_r[c] <= bot_nxt[c];
      end
      res_r <= res_nxt;
    end
  end

  assign res_push = en && v3_r;
  assign res_data = res_r;

endmodule
`default_nettype wire

// File: design/bilinear_resize_sampler.sv
// bilinear_resize_sampler: top level with configuration registers and result queue
// instantiates brs_front, brs_mid_queue and brs_back; uses brs_pkg
//
// input channel: push a word when full is low; req_type 0 stores pixel_word at
// (coord_x, coord_y), req_type 1 samples destination pixel (coord_x, coord_y)
// result channel: one word per sample, none per write; the oldest waits on the
// out_ ports while empty is low and leaves on pop
// configuration: cfg_valid with cfg_index and cfg_data, cfg_ready is always high;
// registers are source width, source height, target width, target height
// throughput: one word per cycle while full is low, writes and samples mixed
// freely; the divider pipeline for the coordinate mapping and the four parity
// banks of the image store, each read once a cycle, set that figure
// reset: synchronous, rst_n low clears registers and queues; the image store is
// undefined until written
// stall: when pop stays low the result queue fills, the back end holds, the
// middle queue fills, and full rises until results drain
`timescale 1ns / 1ps
`default_nettype none
module bilinear_resize_sampler (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         in_req_type,
  input  wire logic [11:0]                  in_coord_x,
  input  wire logic [11:0]                  in_coord_y,
  input  wire logic [31:0]                  in_pixel_word,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              out_ok,
  output logic [7:0]                        out_blue,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_alpha,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [brs_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [11:0]                  cfg_data
);

  brs_pkg::sz_t  src_w_r, src_h_r, src_w, src_h;
  brs_pkg::dim_t dst_w_r, dst_h_r;

  logic          q_full, q_empty, q_push, q_pop;
  brs_pkg::mid_t q_data, q_head;

  logic          res_push, res_space;
  brs_pkg::res_t res_data;

  brs_pkg::res_t           ofq_r [brs_pkg::OUT_DEPTH];
  logic [brs_pkg::OPW-1:0] owp_r, orp_r;
  logic [brs_pkg::OCW-1:0] ocnt_r;
  logic                    out_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= '0;
      src_h_r <= '0;
      dst_w_r <= '0;
      dst_h_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        brs_pkg::CFG_SRC_W: src_w_r <= cfg_data[brs_pkg::SZW-1:0];
        brs_pkg::CFG_SRC_H: src_h_r <= cfg_data[brs_pkg::SZW-1:0];
        brs_pkg::CFG_DST_W: dst_w_r <= cfg_data;
        brs_pkg::CFG_DST_H: dst_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign src_w = (int'(src_w_r) > brs_pkg::MAX_SRC_WIDTH) ?
                 brs_pkg::sz_t'(brs_pkg::MAX_SRC_WIDTH) : src_w_r;
  assign src_h = (int'(src_h_r) > brs_pkg::MAX_SRC_HEIGHT) ?
                 brs_pkg::sz_t'(brs_pkg::MAX_SRC_HEIGHT) : src_h_r;

  brs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (push),
    .in_full       (full),
    .in_req_type   (in_req_type),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_pixel_word (in_pixel_word),
    .src_w         (src_w),
    .src_h         (src_h),
    .dst_w         (dst_w_r),
    .dst_h         (dst_h_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  brs_mid_queue u_mid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  brs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res_space (res_space),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // result queue
  assign res_space = (ocnt_r != brs_pkg::OCW'(brs_pkg::OUT_DEPTH));
  assign empty     = (ocnt_r == '0);
  assign out_take  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (res_push) begin
        owp_r <= brs_pkg::OPW'(owp_r + 1'b1);
      end
      if (out_take) begin
        orp_r <= brs_pkg::OPW'(orp_r + 1'b1);
      end
      if (res_push && !out_take) begin
        ocnt_r <= ocnt_r + 1'b1;
      end else if (out_take && !res_push) begin
        ocnt_r <= ocnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      ofq_r[owp_r] <= res_data;
    end
  end

  assign out_ok    = ofq_r[orp_r].ok;
  assign out_blue  = ofq_r[orp_r].blue;
  assign out_green = ofq_r[orp_r].green;
  assign out_red   = ofq_r[orp_r].red;
  assign out_alpha = ofq_r[orp_r].alpha;

  a_ocnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= brs_pkg::OCW'(brs_pkg::OUT_DEPTH))
    else $error("result queue count out of range");

  a_push_space : assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (ocnt_r != brs_pkg::OCW'(brs_pkg::OUT_DEPTH)))
    else $error("result pushed into full queue");

  a_push_shows : assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> !empty)
    else $error("pushed result not visible");

  a_mid_push : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("middle queue overrun");

endmodule
`default_nettype wire

// File: tb/sv/tb_bilinear_resize_sampler.sv
// tb_bilinear_resize_sampler: self-checking bench that predicts every sample word of the scaler
// directed table first, then random configuration phases; depends on brs_pkg and the rtl
`timescale 1ns / 1ps
`default_nettype none
module tb_bilinear_resize_sampler;

  localparam int   DRAIN_CYCLES = 40;

  typedef enum int {ROW_CFG, ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t      kind;
    logic [2:0]     idx;
    logic [11:0]    x;
    logic [11:0]    y;
    logic [31:0]    pix;
    bit             typed;
    brs_pkg::res_t  want;
  } row_t;

  typedef struct {
    int unsigned x0, x1, y0, y1, fx, fy;
  } taps_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic in_req_type = 1'b0;
  logic [11:0] in_coord_x = '0;
  logic [11:0] in_coord_y = '0;
  logic [31:0] in_pixel_word = '0;
  logic empty;
  logic pop = 1'b0;
  logic out_ok;
  logic [7:0] out_blue, out_green, out_red, out_alpha;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [brs_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [11:0] cfg_data = '0;

  bilinear_resize_sampler u_dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_req_type(in_req_type), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .in_pixel_word(in_pixel_word),
    .empty(empty), .pop(pop),
    .out_ok(out_ok), .out_blue(out_blue), .out_green(out_green), .out_red(out_red),
    .out_alpha(out_alpha),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  brs_pkg::sz_t  src_w_reg = '0, src_h_reg = '0;
  brs_pkg::dim_t dst_w_reg = '0, dst_h_reg = '0;
  logic [31:0]   pixels [brs_pkg::MAX_SRC_WIDTH*brs_pkg::MAX_SRC_HEIGHT];
  bit            written [brs_pkg::MAX_SRC_WIDTH*brs_pkg::MAX_SRC_HEIGHT];
  brs_pkg::res_t sample_q [$];
  row_t          plan [$];
  int            errors = 0;
  int            items_sent = 0;
  bit            burst = 1'b0;

  function automatic int unsigned eff_width();
    return (src_w_reg > brs_pkg::MAX_SRC_WIDTH) ? brs_pkg::MAX_SRC_WIDTH : src_w_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (src_h_reg > brs_pkg::MAX_SRC_HEIGHT) ? brs_pkg::MAX_SRC_HEIGHT : src_h_reg;
  endfunction

  function automatic bit sample_valid(logic [11:0] x, logic [11:0] y);
    return eff_width() != 0 && eff_height() != 0 && x < dst_w_reg && y < dst_h_reg;
  endfunction

  // half-pixel-centre back mapping in fixed point, clamped to the image
  function automatic longint unsigned map_axis(longint unsigned d, longint unsigned src,
                                               longint unsigned dst);
    longint unsigned num, off, lim, q;
    num = ((2 * d + 1) * src) << brs_pkg::FRAC_BITS;
    off = dst << brs_pkg::FRAC_BITS;
    lim = (src - 1) << brs_pkg::FRAC_BITS;
    if (num <= off) return 0;
    q = (num - off) / (2 * dst);
    return (q > lim) ? lim : q;
  endfunction

  function automatic taps_t find_taps(logic [11:0] x, logic [11:0] y);
    taps_t t;
    longint unsigned sx, sy;
    int unsigned w, h;
    w  = eff_width();
    h  = eff_height();
    sx = map_axis(x, w, dst_w_reg);
    sy = map_axis(y, h, dst_h_reg);
    t.x0 = 32'(sx >> brs_pkg::FRAC_BITS);
    t.y0 = 32'(sy >> brs_pkg::FRAC_BITS);
    t.fx = 32'(sx & ((1 << brs_pkg::FRAC_BITS) - 1));
    t.fy = 32'(sy & ((1 << brs_pkg::FRAC_BITS) - 1));
    t.x1 = (t.x0 + 1 < w) ? t.x0 + 1 : w - 1;
    t.y1 = (t.y0 + 1 < h) ? t.y0 + 1 : h - 1;
    return t;
  endfunction

  function automatic int unsigned texel(int unsigned x, int unsigned y, int ch);
    logic [31:0] p;
    p = pixels[y * brs_pkg::MAX_SRC_WIDTH + x];
    return (p >> (8 * ch)) & 8'hff;
  endfunction

  function automatic brs_pkg::res_t blend_sample(logic [11:0] x, logic [11:0] y);
    brs_pkg::res_t r;
    taps_t t;
    longint unsigned one, top, bot, v;
    logic [7:0] ch_val [4];
    r = '0;
    if (!sample_valid(x, y)) return r;
    t   = find_taps(x, y);
    one = 1 << brs_pkg::FRAC_BITS;
    for (int ch = 0; ch < 4; ch++) begin
      top = texel(t.x0, t.y0, ch) * (one - t.fx) + texel(t.x1, t.y0, ch) * t.fx;
      bot = texel(t.x0, t.y1, ch) * (one - t.fx) + texel(t.x1, t.y1, ch) * t.fx;
      v   = (top * (one - t.fy) + bot * t.fy) >> (2 * brs_pkg::FRAC_BITS);
      ch_val[ch] = (v > 255) ? 8'hff : v[7:0];
    end
    r.ok    = 1'b1;
    r.blue  = ch_val[0];
    r.green = ch_val[1];
    r.red   = ch_val[2];
    r.alpha = ch_val[3];
    return r;
  endfunction

  task automatic send_word(logic kind, logic [11:0] x, logic [11:0] y, logic [31:0] pix,
                           bit typed, brs_pkg::res_t want);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push          = 1'b1;
    in_req_type   = kind;
    in_coord_x    = x;
    in_coord_y    = y;
    in_pixel_word = pix;
    @(posedge clk);
    while (full) @(posedge clk);
    if (kind == brs_pkg::REQ_WRITE) begin
      if (x < brs_pkg::MAX_SRC_WIDTH && y < brs_pkg::MAX_SRC_HEIGHT) begin
        pixels[y * brs_pkg::MAX_SRC_WIDTH + x]  = pix;
        written[y * brs_pkg::MAX_SRC_WIDTH + x] = 1'b1;
      end
    end else begin
      sample_q.push_back(typed ? want : blend_sample(x, y));
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic fill_if_unwritten(int unsigned x, int unsigned y);
    if (!written[y * brs_pkg::MAX_SRC_WIDTH + x])
      send_word(brs_pkg::REQ_WRITE, x[11:0], y[11:0], $urandom, 1'b0, '0);
  endtask

  // never let a sample read a pixel that was not stored yet
  task automatic send_sample(logic [11:0] x, logic [11:0] y, bit typed, brs_pkg::res_t want);
    taps_t t;
    if (sample_valid(x, y)) begin
      t = find_taps(x, y);
      fill_if_unwritten(t.x0, t.y0);
      fill_if_unwritten(t.x1, t.y0);
      fill_if_unwritten(t.x0, t.y1);
      fill_if_unwritten(t.x1, t.y1);
    end
    send_word(brs_pkg::REQ_SAMPLE, x, y, '0, typed, want);
  endtask

  task automatic drain();
    push = 1'b0;
    while (sample_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [brs_pkg::CFG_IW-1:0] idx, logic [11:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      brs_pkg::CFG_SRC_W: src_w_reg = value[brs_pkg::SZW-1:0];
      brs_pkg::CFG_SRC_H: src_h_reg = value[brs_pkg::SZW-1:0];
      brs_pkg::CFG_DST_W: dst_w_reg = value;
      brs_pkg::CFG_DST_H: dst_h_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_row(row_kind_t kind, logic [2:0] idx, logic [11:0] x, logic [11:0] y,
                         logic [31:0] pix, bit typed);
    row_t r;
    r.kind  = kind;
    r.idx   = idx;
    r.x     = x;
    r.y     = y;
    r.pix   = pix;
    r.typed = typed;
    r.want  = '0;
    plan.push_back(r);
  endtask

  function automatic logic [11:0] pick_src();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 12'($urandom_range(0, 7) << 9);
    if (r == 1) return 12'd256;
    if (r == 2) return 12'($urandom_range(257, 4095));
    if (r == 3) return 12'd1;
    return 12'($urandom_range(2, 12));
  endfunction

  function automatic logic [11:0] pick_dst();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 12'd0;
    if (r == 1) return 12'd4095;
    if (r == 2) return 12'd1;
    return 12'($urandom_range(1, 24));
  endfunction

  // result side
  initial begin
    brs_pkg::res_t want;
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = burst ? 0 : $urandom_range(0, 6);
      pop = 1'b0;
      repeat (gap) @(negedge clk);
      pop = 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (sample_q.size() == 0) begin
        $display("%0t: unexpected word ok=%0b bgra=%02h %02h %02h %02h", $time, out_ok,
                 out_blue, out_green, out_red, out_alpha);
        errors++;
      end else begin
        want = sample_q.pop_front();
        if (out_ok !== want.ok) begin
          $display("%0t: ok expected %0b actual %0b", $time, want.ok, out_ok);
          errors++;
        end
        if (out_blue !== want.blue) begin
          $display("%0t: blue expected %02h actual %02h", $time, want.blue, out_blue);
          errors++;
        end
        if (out_green !== want.green) begin
          $display("%0t: green expected %02h actual %02h", $time, want.green, out_green);
          errors++;
        end
        if (out_red !== want.red) begin
          $display("%0t: red expected %02h actual %02h", $time, want.red, out_red);
          errors++;
        end
        if (out_alpha !== want.alpha) begin
          $display("%0t: alpha expected %02h actual %02h", $time, want.alpha, out_alpha);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned w, h, n, r;
    logic [11:0] sx, sy;
    logic [11:0] sw, sh;
    // empty source after reset
    add_row(ROW_SAMPLE, 0, 12'd0, 12'd0, 32'h0, 1'b1);
    add_row(ROW_CFG, brs_pkg::CFG_SRC_W, 12'd2, 0, 0, 1'b0);
    add_row(ROW_CFG, brs_pkg::CFG_SRC_H, 12'd2, 0, 0, 1'b0);
    add_row(ROW_CFG, brs_pkg::CFG_DST_W, 12'd4, 0, 0, 1'b0);
    add_row(ROW_CFG, brs_pkg::CFG_DST_H, 12'd4, 0, 0, 1'b0);
    add_row(ROW_WRITE, 0, 12'd0, 12'd0, 32'h0000_0000, 1'b0);
    add_row(ROW_WRITE, 0, 12'd1, 12'd0, 32'hffff_ffff, 1'b0);
    add_row(ROW_WRITE, 0, 12'd0, 12'd1, 32'h1234_5678, 1'b0);
    add_row(ROW_WRITE, 0, 12'd1, 12'd1, 32'ha5c3_f00f, 1'b0);
    // writes outside the store are dropped
    add_row(ROW_WRITE, 0, 12'd4095, 12'd4095, 32'hdead_beef, 1'b0);
    add_row(ROW_WRITE, 0, 12'd256, 12'd0, 32'hdead_beef, 1'b0);
    add_row(ROW_WRITE, 0, 12'd0, 12'd256, 32'hdead_beef, 1'b0);
    add_row(ROW_SAMPLE, 0, 12'd0, 12'd0, 0, 1'b0);
    add_row(ROW_SAMPLE, 0, 12'd3, 12'd3, 0, 1'b0);
    add_row(ROW_SAMPLE, 0, 12'd1, 12'd2, 0, 1'b0);
    add_row(ROW_SAMPLE, 0, 12'd4, 12'd0, 0, 1'b1);
    add_row(ROW_SAMPLE, 0, 12'd0, 12'd4, 0, 1'b1);
    add_row(ROW_SAMPLE, 0, 12'd4095, 12'd4095, 0, 1'b1);
    add_row(ROW_CFG, brs_pkg::CFG_DST_W, 12'd0, 0, 0, 1'b0);
    add_row(ROW_SAMPLE, 0, 12'd0, 12'd0, 0, 1'b1);
    // oversized source width, widest target
    add_row(ROW_CFG, brs_pkg::CFG_SRC_W, 12'hfff, 0, 0, 1'b0);
    add_row(ROW_CFG, brs_pkg::CFG_DST_W, 12'd4095, 0, 0, 1'b0);
    add_row(ROW_SAMPLE, 0, 12'd4094, 12'd3, 0, 1'b0);
    add_row(ROW_SAMPLE, 0, 12'd2047, 12'd0, 0, 1'b0);
    add_row(ROW_CFG, brs_pkg::CFG_SRC_W, 12'd0, 0, 0, 1'b0);
    add_row(ROW_SAMPLE, 0, 12'd0, 12'd0, 0, 1'b1);

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          drain();
          write_reg(plan[i].idx, plan[i].x);
        end
        ROW_WRITE: send_word(brs_pkg::REQ_WRITE, plan[i].x, plan[i].y, plan[i].pix, 1'b0,
                             '0);
        default: send_sample(plan[i].x, plan[i].y, plan[i].typed, plan[i].want);
      endcase
    end

    while (items_sent < 1900) begin
      drain();
      burst = ($urandom_range(0, 3) == 0);
      sw = pick_src();
      sh = pick_src();
      write_reg(brs_pkg::CFG_SRC_W, sw);
      write_reg(brs_pkg::CFG_SRC_H, sh);
      write_reg(brs_pkg::CFG_DST_W, pick_dst());
      write_reg(brs_pkg::CFG_DST_H, pick_dst());
      w = eff_width();
      h = eff_height();
      if (w * h <= 64)
        for (int yy = 0; yy < h; yy++)
          for (int xx = 0; xx < w; xx++)
            send_word(brs_pkg::REQ_WRITE, xx[11:0], yy[11:0], $urandom, 1'b0, '0);
      n = $urandom_range(30, 80);
      repeat (n) begin
        r = $urandom_range(0, 19);
        if (r < 13 && dst_w_reg != 0 && dst_h_reg != 0) begin
          sx = 12'($urandom_range(0, dst_w_reg - 1));
          sy = 12'($urandom_range(0, dst_h_reg - 1));
          send_sample(sx, sy, 1'b0, '0);
        end else if (r < 16) begin
          send_sample(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), 1'b0, '0);
        end else if (r < 19) begin
          sx = 12'($urandom_range(0, (w != 0) ? w - 1 : brs_pkg::MAX_SRC_WIDTH - 1));
          sy = 12'($urandom_range(0, (h != 0) ? h - 1 : brs_pkg::MAX_SRC_HEIGHT - 1));
          send_word(brs_pkg::REQ_WRITE, sx, sy, $urandom, 1'b0, '0);
        end else begin
          send_word(brs_pkg::REQ_WRITE, 12'($urandom_range(0, 4095)),
                    12'($urandom_range(0, 4095)), $urandom, 1'b0, '0);
        end
      end
    end

    burst = 1'b0;
    drain();
    if (errors == 0) begin
      $display("bilinear_resize_sampler regression: pass");
    end else begin
      $display("bilinear_resize_sampler regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("bilinear_resize_sampler regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
